// ----- sv/kfm_pkg.sv -----
// Shared types and codes for the keyed multi-queue manager.
// Standalone package with no dependencies; used by the top level and the testbench.
package kfm_pkg;

	localparam int KEY_W = 32;
	localparam int PID_W = 22;
	localparam int CNT_W = 9;

	typedef logic [KEY_W-1:0] key_t;
	typedef logic [PID_W-1:0] pid_t;
	typedef logic [CNT_W-1:0] count_t;

	typedef enum logic [2:0] {
		OP_INIT     = 3'd0,
		OP_SHUTDOWN = 3'd1,
		OP_CREATE   = 3'd2,
		OP_DESTROY  = 3'd3,
		OP_SEND     = 3'd4,
		OP_PEEK     = 3'd5,
		OP_POP      = 3'd6,
		OP_COUNT    = 3'd7
	} opcode_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_EXISTS  = 3'd1,
		ST_NOINIT  = 3'd2,
		ST_NOKEY   = 3'd3,
		ST_EMPTY   = 3'd4,
		ST_NOSPACE = 3'd5
	} status_t;

	typedef struct packed {
		opcode_t opcode;
		key_t    key;
		pid_t    pid;
	} req_t;

	typedef struct packed {
		status_t status;
		pid_t    pid_out;
		count_t  queue_count;
	} rsp_t;

endpackage

// ----- sv/kfm_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies; used for the entry id and entry link stores.
module kfm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- sv/keyed_multi_fifo_manager_top.sv -----
// Keyed multi-queue manager: FIFO queues of process ids named by 32-bit keys.
// A request is registered in the request stage; the result register then raises done.
// Busy is a registered copy of the transfer (start while busy is low), so a new
// request is taken only while busy is low.
// Reset clears all keys and queues at once; no clearing pass. The receiver cannot stall.
// Depends on kfm_pkg and kfm_ram.
module keyed_multi_fifo_manager_top #(
	parameter int MAX_KEYS    = 16,
	parameter int MAX_ENTRIES = 256
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  kfm_pkg::req_t req,
	output logic          busy,
	output logic          done,
	output kfm_pkg::rsp_t rsp
);

	localparam int KW = $clog2(MAX_KEYS);
	localparam int EW = $clog2(MAX_ENTRIES);
	localparam int LW = $clog2(MAX_ENTRIES + 1);

	// Key table. The valid bits and queue lengths are reset; the key values,
	// head and tail pointers are only read once their slot has been written.
	logic                  key_vld_q [MAX_KEYS];
	kfm_pkg::key_t         key_val_q [MAX_KEYS];
	logic [EW-1:0]         q_head_q  [MAX_KEYS];
	logic [EW-1:0]         q_tail_q  [MAX_KEYS];
	logic [LW-1:0]         q_len_q   [MAX_KEYS];

	logic                  init_q;

	// Free entries are split in two pools: a linked list of entries that have
	// been released, and a region of entries never handed out since the last
	// reset or shutdown (indices fresh_q and up). Which entry is handed out is
	// invisible at the ports, so the store needs no link initialization.
	logic [EW-1:0]         fl_head_q;
	logic [LW-1:0]         fl_cnt_q;
	logic [LW-1:0]         fresh_q;

	// Request stage: the request, its key lookup and the RAM read it caused.
	logic                  busy_s1;
	kfm_pkg::req_t         req_s1;
	logic                  hit_s1;
	logic [KW-1:0]         idx_s1;

	logic                  done_q;
	kfm_pkg::rsp_t         rsp_q;

	logic                  accept;
	logic                  hit;
	logic [KW-1:0]         hit_idx;
	logic [EW-1:0]         ram_raddr;
	kfm_pkg::pid_t         id_rdata;
	logic [EW-1:0]         lk_rdata;

	assign accept = start && !busy_s1;
	assign busy   = busy_s1;
	assign done   = done_q;
	assign rsp    = rsp_q;

	// Parallel key search on the incoming request. Keys are unique, so at most
	// one slot matches; the loop keeps the lowest one regardless.
	always_comb begin
		hit     = 1'b0;
		hit_idx = '0;
		for (int i = MAX_KEYS - 1; i >= 0; i--) begin
			if (key_vld_q[i] && (key_val_q[i] == req.key)) begin
				hit     = 1'b1;
				hit_idx = KW'(i);
			end
		end
	end

	// A send reads the link of the free-list head so that the list can advance;
	// every other request reads the head entry of its queue (id and link).
	assign ram_raddr = (req.opcode == kfm_pkg::OP_SEND) ? fl_head_q : q_head_q[hit_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
		end else begin
			busy_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req;
			hit_s1 <= hit;
			idx_s1 <= hit_idx;
		end
	end

	// Lowest free key slot, used by create.
	logic          slot_found;
	logic [KW-1:0] slot_idx;

	always_comb begin
		slot_found = 1'b0;
		slot_idx   = '0;
		for (int i = MAX_KEYS - 1; i >= 0; i--) begin
			if (!key_vld_q[i]) begin
				slot_found = 1'b1;
				slot_idx   = KW'(i);
			end
		end
	end

	// Execute stage: every update of the request is decided here and lands at
	// the end of the cycle, together with the result.
	logic              init_set;
	logic              clear_all;
	logic              create_we;
	logic              upd_head;
	logic              upd_tail;
	logic              upd_len;
	logic [EW-1:0]     new_head;
	logic [EW-1:0]     new_tail;
	logic [LW-1:0]     new_len;
	logic [EW-1:0]     fl_head_nxt;
	logic [LW-1:0]     fl_cnt_nxt;
	logic [LW-1:0]     fresh_nxt;
	logic              id_we;
	logic [EW-1:0]     id_waddr;
	logic              lk_we;
	logic [EW-1:0]     lk_waddr;
	logic [EW-1:0]     lk_wdata;
	logic [EW-1:0]     alloc;
	logic [LW-1:0]     cur_len;
	kfm_pkg::rsp_t     rsp_nxt;

	assign cur_len = q_len_q[idx_s1];

	always_comb begin
		init_set    = 1'b0;
		clear_all   = 1'b0;
		create_we   = 1'b0;
		upd_head    = 1'b0;
		upd_tail    = 1'b0;
		upd_len     = 1'b0;
		new_head    = q_head_q[idx_s1];
		new_tail    = q_tail_q[idx_s1];
		new_len     = cur_len;
		fl_head_nxt = fl_head_q;
		fl_cnt_nxt  = fl_cnt_q;
		fresh_nxt   = fresh_q;
		id_we       = 1'b0;
		id_waddr    = '0;
		lk_we       = 1'b0;
		lk_waddr    = '0;
		lk_wdata    = '0;
		alloc       = (fl_cnt_q != '0) ? fl_head_q : fresh_q[EW-1:0];
		rsp_nxt.status      = kfm_pkg::ST_OK;
		rsp_nxt.pid_out     = '0;
		rsp_nxt.queue_count = '0;

		if (req_s1.opcode == kfm_pkg::OP_INIT) begin
			if (init_q) begin
				rsp_nxt.status = kfm_pkg::ST_EXISTS;
			end else begin
				init_set = 1'b1;
			end
		end else if (!init_q) begin
			rsp_nxt.status = kfm_pkg::ST_NOINIT;
		end else begin
			case (req_s1.opcode)
				kfm_pkg::OP_SHUTDOWN: begin
					clear_all = 1'b1;
				end
				kfm_pkg::OP_CREATE: begin
					if (hit_s1) begin
						rsp_nxt.status = kfm_pkg::ST_EXISTS;
					end else if (!slot_found) begin
						rsp_nxt.status = kfm_pkg::ST_NOSPACE;
					end else begin
						create_we = 1'b1;
					end
				end
				default: begin
					if (!hit_s1) begin
						rsp_nxt.status = kfm_pkg::ST_NOKEY;
					end else begin
						case (req_s1.opcode)
							kfm_pkg::OP_COUNT: begin
								rsp_nxt.queue_count = kfm_pkg::count_t'(cur_len);
							end
							kfm_pkg::OP_SEND: begin
								if ((fl_cnt_q == '0) && (fresh_q == LW'(MAX_ENTRIES))) begin
									rsp_nxt.status = kfm_pkg::ST_NOSPACE;
								end else begin
									if (fl_cnt_q != '0) begin
										fl_head_nxt = lk_rdata;
										fl_cnt_nxt  = fl_cnt_q - LW'(1);
									end else begin
										fresh_nxt = fresh_q + LW'(1);
									end
									id_we    = 1'b1;
									id_waddr = alloc;
									if (cur_len == '0) begin
										upd_head = 1'b1;
										new_head = alloc;
									end else begin
										lk_we    = 1'b1;
										lk_waddr = q_tail_q[idx_s1];
										lk_wdata = alloc;
									end
									upd_tail = 1'b1;
									new_tail = alloc;
									upd_len  = 1'b1;
									new_len  = cur_len + LW'(1);
								end
							end
							default: begin
								if (cur_len == '0) begin
									rsp_nxt.status = kfm_pkg::ST_EMPTY;
								end else begin
									case (req_s1.opcode)
										kfm_pkg::OP_DESTROY: begin
											// The whole chain goes onto the free list at once.
											lk_we       = 1'b1;
											lk_waddr    = q_tail_q[idx_s1];
											lk_wdata    = fl_head_q;
											fl_head_nxt = q_head_q[idx_s1];
											fl_cnt_nxt  = fl_cnt_q + cur_len;
											upd_len     = 1'b1;
											new_len     = '0;
										end
										kfm_pkg::OP_PEEK: begin
											rsp_nxt.pid_out = id_rdata;
										end
										kfm_pkg::OP_POP: begin
											rsp_nxt.pid_out = id_rdata;
											upd_head        = 1'b1;
											new_head        = lk_rdata;
											upd_len         = 1'b1;
											new_len         = cur_len - LW'(1);
											lk_we           = 1'b1;
											lk_waddr        = q_head_q[idx_s1];
											lk_wdata        = fl_head_q;
											fl_head_nxt     = q_head_q[idx_s1];
											fl_cnt_nxt      = fl_cnt_q + LW'(1);
										end
										default: begin
										end
									endcase
								end
							end
						endcase
					end
				end
			endcase
		end
	end

	// Entry store: process ids and next-entry links.
	kfm_ram #(
		.WIDTH(kfm_pkg::PID_W),
		.DEPTH(MAX_ENTRIES)
	) u_id_ram (
		.clk   (clk),
		.we    (busy_s1 && id_we),
		.waddr (id_waddr),
		.wdata (req_s1.pid),
		.raddr (ram_raddr),
		.rdata (id_rdata)
	);

	kfm_ram #(
		.WIDTH(EW),
		.DEPTH(MAX_ENTRIES)
	) u_link_ram (
		.clk   (clk),
		.we    (busy_s1 && lk_we),
		.waddr (lk_waddr),
		.wdata (lk_wdata),
		.raddr (ram_raddr),
		.rdata (lk_rdata)
	);

	// Control state: initialized flag, key valid bits, queue lengths, free pools.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q    <= 1'b0;
			fl_head_q <= '0;
			fl_cnt_q  <= '0;
			fresh_q   <= '0;
			for (int i = 0; i < MAX_KEYS; i++) begin
				key_vld_q[i] <= 1'b0;
				q_len_q[i]   <= '0;
			end
		end else if (busy_s1) begin
			if (clear_all) begin
				init_q   <= 1'b0;
				fl_cnt_q <= '0;
				fresh_q  <= '0;
				for (int i = 0; i < MAX_KEYS; i++) begin
					key_vld_q[i] <= 1'b0;
					q_len_q[i]   <= '0;
				end
			end else begin
				if (init_set) begin
					init_q <= 1'b1;
				end
				fl_head_q <= fl_head_nxt;
				fl_cnt_q  <= fl_cnt_nxt;
				fresh_q   <= fresh_nxt;
				if (create_we) begin
					key_vld_q[slot_idx] <= 1'b1;
					q_len_q[slot_idx]   <= '0;
				end
				if (upd_len) begin
					q_len_q[idx_s1] <= new_len;
				end
			end
		end
	end

	// Key values and queue pointers carry no reset.
	always_ff @(posedge clk) begin
		if (busy_s1) begin
			if (create_we) begin
				key_val_q[slot_idx] <= req_s1.key;
			end
			if (upd_head) begin
				q_head_q[idx_s1] <= new_head;
			end
			if (upd_tail) begin
				q_tail_q[idx_s1] <= new_tail;
			end
		end
	end

	// Result register: one strobe per request, one cycle wide.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= busy_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (busy_s1) begin
			rsp_q <= rsp_nxt;
		end
	end

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for keyed_multi_fifo_manager_top: directed table, then random phases.
// Expected responses come from an in-bench predictor of the key table and shared entry store.
// Depends on kfm_pkg and the RTL of the block only.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import kfm_pkg::*;

	localparam int CLK_PERIOD  = 2;
	localparam int NUM_KEYS    = 16;
	localparam int NUM_ENTRIES = 256;
	localparam int TOTAL_ITEMS = 1850;
	localparam int POOL_SIZE   = 20;
	localparam int DIR_ROWS    = 25;
	localparam int CYCLE_LIMIT = 200000;
	// Idle clocks that run after the last response has come back, before the verdict.
	localparam int TAIL_CYCLES = 8;

	typedef logic [$clog2(NUM_ENTRIES)-1:0] entry_idx_t;

	// Stimulus phases: fill pushes the store toward full, drain empties it, mix does a bit of all.
	typedef enum {PH_FILL, PH_MIX, PH_DRAIN} phase_e;

	// One row of the directed table. When chk is set, the predictor's answer must also match
	// the response typed into the row.
	typedef struct packed {
		opcode_t op;
		key_t    key;
		pid_t    pid;
		logic    chk;
		rsp_t    exp;
	} dir_row_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic start  = 1'b0;
	req_t req    = '0;
	logic busy;
	logic done;
	rsp_t rsp;

	// Shadow copy of the block's state, advanced once per accepted request.
	logic       in_init;
	logic       slot_used [NUM_KEYS];
	key_t       slot_key  [NUM_KEYS];
	entry_idx_t q_head    [NUM_KEYS];
	entry_idx_t q_tail    [NUM_KEYS];
	count_t     q_len     [NUM_KEYS];
	pid_t       ent_pid   [NUM_ENTRIES];
	entry_idx_t ent_next  [NUM_ENTRIES];
	entry_idx_t free_ptr;
	count_t     free_left;

	rsp_t pending_rsp [$];   // predicted responses still owed by the block
	key_t key_pool [POOL_SIZE];
	int   err_cnt   = 0;
	int   cycle_cnt = 0;
	int   n_sent    = 0;
	logic quiet     = 1'b0;  // no sender gaps while set
	logic tbl_chk   = 1'b0;
	rsp_t tbl_exp   = '0;

	dir_row_t dir_tab [DIR_ROWS] = '{
		'{OP_PEEK,     32'h0000_0000, 22'h000000, 1'b1, '{ST_NOINIT,  22'h000000, 9'd0}},
		'{OP_INIT,     32'h0000_0000, 22'h000000, 1'b1, '{ST_OK,      22'h000000, 9'd0}},
		'{OP_INIT,     32'h0000_0000, 22'h3FFFFF, 1'b1, '{ST_EXISTS,  22'h000000, 9'd0}},
		'{OP_CREATE,   32'h0000_0000, 22'h000000, 1'b1, '{ST_OK,      22'h000000, 9'd0}},
		'{OP_CREATE,   32'h0000_0000, 22'h000000, 1'b1, '{ST_EXISTS,  22'h000000, 9'd0}},
		'{OP_CREATE,   32'hFFFF_FFFF, 22'h000000, 1'b1, '{ST_OK,      22'h000000, 9'd0}},
		'{OP_SEND,     32'h0000_0000, 22'h3FFFFF, 1'b1, '{ST_OK,      22'h000000, 9'd0}},
		'{OP_SEND,     32'h0000_0000, 22'h000000, 1'b1, '{ST_OK,      22'h000000, 9'd0}},
		'{OP_PEEK,     32'h0000_0000, 22'h000000, 1'b1, '{ST_OK,      22'h3FFFFF, 9'd0}},
		'{OP_COUNT,    32'h0000_0000, 22'h000000, 1'b1, '{ST_OK,      22'h000000, 9'd2}},
		'{OP_POP,      32'h0000_0000, 22'h000000, 1'b1, '{ST_OK,      22'h3FFFFF, 9'd0}},
		'{OP_POP,      32'h0000_0000, 22'h000000, 1'b0, '{ST_OK,      22'h000000, 9'd0}},
		'{OP_POP,      32'h0000_0000, 22'h000000, 1'b1, '{ST_EMPTY,   22'h000000, 9'd0}},
		'{OP_PEEK,     32'h0000_0000, 22'h000000, 1'b1, '{ST_EMPTY,   22'h000000, 9'd0}},
		'{OP_DESTROY,  32'h0000_0000, 22'h000000, 1'b1, '{ST_EMPTY,   22'h000000, 9'd0}},
		'{OP_COUNT,    32'h0000_0000, 22'h000000, 1'b1, '{ST_OK,      22'h000000, 9'd0}},
		'{OP_SEND,     32'hFFFF_FFFF, 22'h155555, 1'b1, '{ST_OK,      22'h000000, 9'd0}},
		'{OP_SEND,     32'hFFFF_FFFF, 22'h2AAAAA, 1'b1, '{ST_OK,      22'h000000, 9'd0}},
		'{OP_DESTROY,  32'hFFFF_FFFF, 22'h000000, 1'b1, '{ST_OK,      22'h000000, 9'd0}},
		'{OP_COUNT,    32'hFFFF_FFFF, 22'h000000, 1'b1, '{ST_OK,      22'h000000, 9'd0}},
		'{OP_SEND,     32'h1234_5678, 22'h2AAAAA, 1'b1, '{ST_NOKEY,   22'h000000, 9'd0}},
		'{OP_POP,      32'h5A5A_A5A5, 22'h000000, 1'b1, '{ST_NOKEY,   22'h000000, 9'd0}},
		'{OP_SHUTDOWN, 32'h0000_0000, 22'h000000, 1'b1, '{ST_OK,      22'h000000, 9'd0}},
		'{OP_COUNT,    32'h0000_0000, 22'h000000, 1'b1, '{ST_NOINIT,  22'h000000, 9'd0}},
		'{OP_CREATE,   32'h0000_0000, 22'h000000, 1'b1, '{ST_NOINIT,  22'h000000, 9'd0}}
	};

	keyed_multi_fifo_manager_top #(
		.MAX_KEYS   (NUM_KEYS),
		.MAX_ENTRIES(NUM_ENTRIES)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.req   (req),
		.busy  (busy),
		.done  (done),
		.rsp   (rsp)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Hard stop in case the block hangs or drops a response.
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Returns every key and entry to the power-up state: no keys, free list chained in order.
	function automatic void wipe_state();
		in_init = 1'b0;
		for (int k = 0; k < NUM_KEYS; k++) begin
			slot_used[k] = 1'b0;
			slot_key[k]  = '0;
			q_head[k]    = '0;
			q_tail[k]    = '0;
			q_len[k]     = '0;
		end
		for (int e = 0; e < NUM_ENTRIES; e++) begin
			ent_pid[e]  = '0;
			ent_next[e] = entry_idx_t'(e + 1);
		end
		free_ptr  = '0;
		free_left = count_t'(NUM_ENTRIES);
	endfunction

	// Parallel key search: index of the slot holding the key, or -1.
	function automatic int lookup_slot(key_t k);
		for (int s = 0; s < NUM_KEYS; s++) begin
			if (slot_used[s] && slot_key[s] == k)
				return s;
		end
		return -1;
	endfunction

	// Applies one request to the shadow state and returns the response the block owes for it.
	function automatic rsp_t apply_request(req_t r);
		rsp_t       o;
		int         s;
		entry_idx_t e;

		o.status      = ST_OK;
		o.pid_out     = '0;
		o.queue_count = '0;
		if (r.opcode == OP_INIT) begin
			if (in_init)
				o.status = ST_EXISTS;
			else
				in_init = 1'b1;
		end else if (!in_init) begin
			o.status = ST_NOINIT;
		end else if (r.opcode == OP_SHUTDOWN) begin
			wipe_state();
		end else if (r.opcode == OP_CREATE) begin
			if (lookup_slot(r.key) >= 0) begin
				o.status = ST_EXISTS;
			end else begin
				s = -1;
				for (int k = NUM_KEYS - 1; k >= 0; k--) begin
					if (!slot_used[k])
						s = k;
				end
				if (s < 0) begin
					o.status = ST_NOSPACE;
				end else begin
					slot_used[s] = 1'b1;
					slot_key[s]  = r.key;
					q_len[s]     = '0;
				end
			end
		end else begin
			s = lookup_slot(r.key);
			if (s < 0) begin
				o.status = ST_NOKEY;
			end else if (r.opcode == OP_COUNT) begin
				o.queue_count = q_len[s];
			end else if (r.opcode == OP_SEND) begin
				if (free_left == '0) begin
					o.status = ST_NOSPACE;
				end else begin
					e          = free_ptr;
					free_ptr   = ent_next[e];
					free_left  = free_left - count_t'(1);
					ent_pid[e] = r.pid;
					if (q_len[s] == '0)
						q_head[s] = e;
					else
						ent_next[q_tail[s]] = e;
					q_tail[s] = e;
					q_len[s]  = q_len[s] + count_t'(1);
				end
			end else if (q_len[s] == '0) begin
				o.status = ST_EMPTY;
			end else if (r.opcode == OP_DESTROY) begin
				// The whole chain goes back onto the free list in one splice.
				ent_next[q_tail[s]] = free_ptr;
				free_ptr            = q_head[s];
				free_left           = free_left + q_len[s];
				q_len[s]            = '0;
			end else begin
				e         = q_head[s];
				o.pid_out = ent_pid[e];
				if (r.opcode == OP_POP) begin
					q_head[s]   = ent_next[e];
					q_len[s]    = q_len[s] - count_t'(1);
					ent_next[e] = free_ptr;
					free_ptr    = e;
					free_left   = free_left + count_t'(1);
				end
			end
		end
		return o;
	endfunction

	task automatic log_mismatch(string what, rsp_t want, rsp_t got);
		err_cnt++;
		if (err_cnt <= 10)
			$display("mismatch (%s): expected status %0d pid %06h count %0d, %s",
				what, want.status, want.pid_out, want.queue_count,
				$sformatf("got status %0d pid %06h count %0d",
					got.status, got.pid_out, got.queue_count));
	endtask

	// Monitor and scoreboard. Everything is sampled at the rising edge, before the block's
	// registers update. A response is compared before the transfer of the same edge is
	// predicted; the two never belong to the same request anyway.
	always @(posedge clk) begin
		rsp_t want;
		rsp_t pred;
		if (arst_n) begin
			if (done) begin
				if (pending_rsp.size() == 0) begin
					log_mismatch("response with nothing pending", '0, rsp);
				end else begin
					want = pending_rsp.pop_front();
					if (rsp !== want)
						log_mismatch("response", want, rsp);
				end
			end
			if (start && !busy) begin
				pred = apply_request(req);
				if (tbl_chk && pred !== tbl_exp)
					log_mismatch("directed row", tbl_exp, pred);
				pending_rsp.push_back(pred);
			end
		end
	end

	// Picks a key. Most requests name a live key so that queues actually grow and shrink;
	// creates draw from the pool, which also holds both extreme keys, and a few requests
	// carry a fully random key that almost never matches.
	function automatic key_t pick_key(logic for_create);
		int live [$];
		int r;
		r = $urandom_range(99);
		if (r < 6)
			return key_t'($urandom);
		if (!for_create && r < 90) begin
			for (int s = 0; s < NUM_KEYS; s++) begin
				if (slot_used[s])
					live.push_back(s);
			end
			if (live.size() != 0)
				return slot_key[live[$urandom_range(live.size() - 1)]];
		end
		return key_pool[$urandom_range(POOL_SIZE - 1)];
	endfunction

	// Operation mix per phase. While the block is down, it mostly gets an init, with the
	// occasional stray request that must bounce with the not-initialized status.
	function automatic opcode_t choose_op(phase_e ph);
		int r;
		r = $urandom_range(99);
		if (!in_init)
			return (r < 85) ? OP_INIT : opcode_t'($urandom_range(7));
		case (ph)
			PH_FILL: begin
				if (r < 88) return OP_SEND;
				if (r < 94) return OP_CREATE;
				if (r < 96) return OP_POP;
				if (r < 98) return OP_PEEK;
				return OP_COUNT;
			end
			PH_DRAIN: begin
				if (r < 45) return OP_POP;
				if (r < 60) return OP_DESTROY;
				if (r < 72) return OP_PEEK;
				if (r < 84) return OP_COUNT;
				if (r < 96) return OP_SEND;
				return OP_CREATE;
			end
			default: begin
				if (r < 2)  return OP_INIT;
				if (r < 3)  return OP_SHUTDOWN;
				if (r < 15) return OP_CREATE;
				if (r < 20) return OP_DESTROY;
				if (r < 52) return OP_SEND;
				if (r < 65) return OP_PEEK;
				if (r < 85) return OP_POP;
				return OP_COUNT;
			end
		endcase
	endfunction

	// Drives one request from a falling edge and returns at the falling edge after its
	// transfer, with start still high. Random gaps come first, unless the quiet window is on.
	task automatic issue_req(req_t r, logic chk, rsp_t want);
		quiet = (n_sent >= 700 && n_sent < 1000);
		while (!quiet && $urandom_range(99) < 22) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start   <= 1'b1;
		req     <= r;
		tbl_chk = chk;
		tbl_exp = want;
		do @(posedge clk); while (busy);
		n_sent++;
		@(negedge clk);
	endtask

	// Holds the sender off until every pending response has come back.
	task automatic drain_wait();
		start <= 1'b0;
		while (pending_rsp.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		req_t   nxt;
		phase_e ph;
		int     ph_len;
		int     pick;

		wipe_state();
		key_pool[0] = 32'h0000_0000;
		key_pool[1] = 32'hFFFF_FFFF;
		for (int i = 2; i < POOL_SIZE; i++)
			key_pool[i] = key_t'($urandom);

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part: every opcode, the extremes of key and id, and all errors but no-space.
		for (int i = 0; i < DIR_ROWS; i++) begin
			nxt.opcode = dir_tab[i].op;
			nxt.key    = dir_tab[i].key;
			nxt.pid    = dir_tab[i].pid;
			issue_req(nxt, dir_tab[i].chk, dir_tab[i].exp);
		end
		drain_wait();

		// Random part. The first phase always fills, so both the full key table and the
		// exhausted entry store are reached early; later phases are picked at random.
		ph     = PH_FILL;
		ph_len = 360;
		while (n_sent < TOTAL_ITEMS) begin
			for (int i = 2; i < POOL_SIZE; i++) begin
				if ($urandom_range(3) == 0)
					key_pool[i] = key_t'($urandom);
			end
			for (int j = 0; j < ph_len && n_sent < TOTAL_ITEMS; j++) begin
				nxt.opcode = choose_op(ph);
				nxt.key    = pick_key(nxt.opcode == OP_CREATE);
				pick       = $urandom_range(99);
				if (pick < 5)
					nxt.pid = '0;
				else if (pick < 10)
					nxt.pid = '1;
				else
					nxt.pid = pid_t'($urandom);
				issue_req(nxt, 1'b0, '0);
			end
			if ($urandom_range(1) == 0)
				drain_wait();
			pick = $urandom_range(3);
			ph     = (pick == 0) ? PH_FILL : (pick == 3) ? PH_DRAIN : PH_MIX;
			ph_len = (ph == PH_FILL) ? $urandom_range(200, 330) : $urandom_range(100, 250);
		end

		drain_wait();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_cnt == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
